@@ design/rfp_pkg.sv @@
package rfp_pkg;

   typedef logic [1:0]         command_type;
   typedef logic [7:0]         byte_type;
   typedef logic [1:0]         status_type;
   typedef logic signed [63:0] number_type;
   typedef logic [29:0]        length_type;

   // frame kinds, sampled with the first byte of a frame
   localparam command_type CmdSimple  = 2'd0;
   localparam command_type CmdInteger = 2'd1;
   localparam command_type CmdBulk    = 2'd2;

   // frame end status
   localparam status_type StOk      = 2'd0;
   localparam status_type StFraming = 2'd1;
   localparam status_type StNumber  = 2'd2;

   localparam byte_type ByteCr    = 8'h0D;
   localparam byte_type ByteLf    = 8'h0A;
   localparam byte_type ByteSpace = 8'h20;
   localparam byte_type ByteTab   = 8'h09;
   localparam byte_type ByteVt    = 8'h0B;
   localparam byte_type ByteFf    = 8'h0C;
   localparam byte_type BytePlus  = 8'h2B;
   localparam byte_type ByteMinus = 8'h2D;
   localparam byte_type ByteZero  = 8'h30;
   localparam byte_type ByteNine  = 8'h39;

   localparam length_type MaxBulkReset = 30'd536870912;

   // one tenth of the largest magnitude, for the overflow test
   localparam logic [63:0] MagTenth = 64'd922337203685477580;

   typedef struct packed {
      command_type command;
      byte_type    data_byte;
   } rfp_step_type;

   typedef struct packed {
      logic       is_frame_end;
      byte_type   payload_byte;
      status_type status;
      number_type number;
   } rfp_result_type;

endpackage

@@ design/rfp_req_if.sv @@
interface rfp_req_if import rfp_pkg::*; ();
   logic        valid;
   logic        ready;
   command_type command;
   byte_type    data_byte;

   modport source (output valid, command, data_byte, input ready);
   modport sink (input valid, command, data_byte, output ready);
endinterface

@@ design/rfp_rsp_if.sv @@
interface rfp_rsp_if import rfp_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       is_frame_end;
   byte_type   payload_byte;
   status_type status;
   number_type number;

   modport source (output valid, is_frame_end, payload_byte, status, number, input ready);
   modport sink (input valid, is_frame_end, payload_byte, status, number, output ready);
endinterface

@@ design/rfp_csr_if.sv @@
interface rfp_csr_if import rfp_pkg::*; ();
   logic       valid;
   logic       ready;
   length_type write_data;

   modport source (output valid, write_data, input ready);
   modport sink (input valid, write_data, output ready);
endinterface

@@ design/resp_frame_parser_unit.sv @@
// channel   dir  handshake     payload
// req_bus   in   valid/ready   command, data_byte
// rsp_bus   out  valid/ready   is_frame_end, payload_byte, status, number
// csr_bus   in   valid/ready   write_data (max_bulk_length)
//
// One byte per cycle sustained while results are taken. A request is parsed out
// of the input register after it is accepted, once the parse stage is not stalled,
// and any result it yields is registered: rsp_bus.valid then holds until taken.
// Synchronous reset clears the parse state and sets the bulk limit to 2^29.
// A held result stalls the parse stage; the input register still takes a
// request while it is empty. csr_bus is always ready.
module resp_frame_parser_unit import rfp_pkg::*; (
   input logic   clock,
   input logic   reset,
   rfp_req_if.sink   req_bus,
   rfp_rsp_if.source rsp_bus,
   rfp_csr_if.sink   csr_bus
);

   logic           in_valid_ff, in_valid_in;
   rfp_step_type   in_step_ff, in_step_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rfp_result_type rsp_data_ff, rsp_data_in;
   length_type     max_len_ff, max_len_in;

   logic           advance;
   logic           step_en;
   logic           has_result;
   rfp_result_type result;

   assign advance         = !rsp_valid_ff || rsp_bus.ready;
   assign step_en         = in_valid_ff && advance;
   assign req_bus.ready   = !in_valid_ff || advance;
   assign csr_bus.ready   = 1'b1;

   assign in_valid_in  = req_bus.ready ? req_bus.valid : in_valid_ff;
   assign in_step_in   = (req_bus.ready && req_bus.valid) ?
                         rfp_step_type'{command: req_bus.command,
                                        data_byte: req_bus.data_byte} :
                         in_step_ff;
   assign rsp_valid_in = advance ? (step_en && has_result) : rsp_valid_ff;
   assign rsp_data_in  = (step_en && has_result) ? result : rsp_data_ff;
   assign max_len_in   = csr_bus.valid ? csr_bus.write_data : max_len_ff;

   rfp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .step       (in_step_ff),
      .max_len    (max_len_ff),
      .has_result (has_result),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_len_ff   <= MaxBulkReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         max_len_ff   <= max_len_in;
      end
      in_step_ff  <= in_step_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.is_frame_end = rsp_data_ff.is_frame_end;
   assign rsp_bus.payload_byte = rsp_data_ff.payload_byte;
   assign rsp_bus.status       = rsp_data_ff.status;
   assign rsp_bus.number       = rsp_data_ff.number;

   // a request parked behind a stalled result must not be lost or changed
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_step_ff))
      else $error("input register changed while parse stage stalled");

   // payload results carry no status and no number
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.is_frame_end |->
         rsp_data_ff.status == StOk && rsp_data_ff.number == 64'sd0)
      else $error("payload result with status or number set");

   // a conversion error never reports a value
   a_number_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.is_frame_end && rsp_data_ff.status == StNumber
         |-> rsp_data_ff.number == 64'sd0)
      else $error("number error result with nonzero number");

   // payload byte field is zero and status is a defined code in frame end results
   a_end_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.is_frame_end |-> rsp_data_ff.payload_byte == 8'd0 &&
         (rsp_data_ff.status == StOk || rsp_data_ff.status == StFraming ||
          rsp_data_ff.status == StNumber))
      else $error("frame end result malformed");

endmodule

@@ design/rfp_core.sv @@
module rfp_core import rfp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           step_en,
   input  rfp_step_type   step,
   input  length_type     max_len,
   output logic           has_result,
   output rfp_result_type result
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_STR, PH_LEAD, PH_BODY, PH_BULK, PH_WANT_CR, PH_WANT_LF
   } phase_type;

   phase_type   phase_ff, phase_in;
   command_type kind_ff, kind_in;
   logic        saw_cr_ff, saw_cr_in;
   logic [63:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic        seen_ff, seen_in;
   logic        stopped_ff, stopped_in;
   logic        nerr_ff, nerr_in;
   length_type  remain_ff, remain_in;

   phase_type   ph;
   logic        start_bad;
   logic        frame_end;
   logic        byte_out;
   status_type  end_status;
   logic [63:0] end_number;
   logic [63:0] value;
   logic [63:0] acc_digit;
   logic [3:0]  digit;
   logic        conv_err;
   logic        is_digit;
   logic        is_blank;
   logic        take;
   length_type  remain_dec;
   byte_type    b;

   assign b          = step.data_byte;
   assign digit      = b[3:0];
   assign is_digit   = b inside {[ByteZero:ByteNine]};
   assign is_blank   = b inside {ByteSpace, ByteTab, ByteVt, ByteFf};
   assign value      = neg_ff ? (64'd0 - acc_ff) : acc_ff;
   assign acc_digit  = (acc_ff << 3) + (acc_ff << 1) + {60'd0, digit};
   assign conv_err   = !seen_ff || nerr_ff || (!neg_ff && acc_ff[63]);
   assign remain_dec = remain_ff - length_type'(1);

   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      saw_cr_in  = saw_cr_ff;
      acc_in     = acc_ff;
      neg_in     = neg_ff;
      seen_in    = seen_ff;
      stopped_in = stopped_ff;
      nerr_in    = nerr_ff;
      remain_in  = remain_ff;
      ph         = phase_ff;
      start_bad  = 1'b0;
      frame_end  = 1'b0;
      byte_out   = 1'b0;
      end_status = StOk;
      end_number = 64'd0;
      take       = 1'b0;

      if (step_en) begin
         if (phase_ff == PH_IDLE) begin
            kind_in = step.command;
            case (step.command)
               CmdSimple:           ph = PH_STR;
               CmdInteger, CmdBulk: ph = PH_LEAD;
               default:             start_bad = 1'b1;
            endcase
         end
         phase_in = ph;

         if (start_bad) begin
            frame_end  = 1'b1;
            end_status = StFraming;
         end else begin
            case (ph)
               PH_BULK: begin
                  remain_in = remain_dec;
                  if (remain_dec == '0) phase_in = PH_WANT_CR;
                  byte_out = 1'b1;
               end
               PH_WANT_CR: begin
                  if (b == ByteCr) begin
                     phase_in = PH_WANT_LF;
                  end else begin
                     frame_end  = 1'b1;
                     end_status = StFraming;
                     end_number = acc_ff;
                  end
               end
               PH_WANT_LF: begin
                  frame_end  = 1'b1;
                  end_status = (b == ByteLf) ? StOk : StFraming;
                  end_number = acc_ff;
               end
               PH_STR, PH_LEAD, PH_BODY: begin
                  if (saw_cr_ff) begin
                     if (b != ByteLf) begin
                        frame_end  = 1'b1;
                        end_status = StFraming;
                     end else if (ph == PH_STR) begin
                        frame_end = 1'b1;
                     end else if (conv_err) begin
                        frame_end  = 1'b1;
                        end_status = StNumber;
                     end else if (kind_ff == CmdInteger) begin
                        frame_end  = 1'b1;
                        end_number = value;
                     end else if ((neg_ff && acc_ff != 64'd0) ||
                                  acc_ff > {34'd0, max_len}) begin
                        frame_end  = 1'b1;
                        end_status = StFraming;
                        end_number = value;
                     end else begin
                        // good bulk length: move on to the payload, or to the trailer if it is empty
                        acc_in    = {34'd0, acc_ff[29:0]};
                        neg_in    = 1'b0;
                        saw_cr_in = 1'b0;
                        remain_in = acc_ff[29:0];
                        phase_in  = (acc_ff[29:0] != '0) ? PH_BULK : PH_WANT_CR;
                     end
                  end else if (b == ByteCr) begin
                     saw_cr_in = 1'b1;
                  end else if (b == ByteLf) begin
                     frame_end  = 1'b1;
                     end_status = StFraming;
                  end else if (ph == PH_STR) begin
                     byte_out = 1'b1;
                  end else begin
                     take = 1'b1;
                     if (ph == PH_LEAD) begin
                        if (is_blank) begin
                           take = 1'b0;
                        end else begin
                           phase_in = PH_BODY;
                           if (b == BytePlus) begin
                              take = 1'b0;
                           end else if (b == ByteMinus) begin
                              neg_in = 1'b1;
                              take   = 1'b0;
                           end
                        end
                     end
                     if (take && !stopped_ff) begin
                        if (is_digit) begin
                           seen_in = 1'b1;
                           if (!nerr_ff) begin
                              if (acc_ff > MagTenth ||
                                  (acc_ff == MagTenth && digit > 4'd8)) begin
                                 nerr_in = 1'b1;
                              end else begin
                                 acc_in = acc_digit;
                              end
                           end
                        end else begin
                           stopped_in = 1'b1;
                        end
                     end
                  end
               end
               default: begin
                  frame_end  = 1'b1;
                  end_status = StFraming;
               end
            endcase
         end

         if (frame_end) begin
            phase_in   = PH_IDLE;
            kind_in    = CmdSimple;
            saw_cr_in  = 1'b0;
            acc_in     = 64'd0;
            neg_in     = 1'b0;
            seen_in    = 1'b0;
            stopped_in = 1'b0;
            nerr_in    = 1'b0;
            remain_in  = '0;
         end
      end

      has_result          = frame_end || byte_out;
      result.is_frame_end = frame_end;
      result.payload_byte = byte_out ? b : 8'd0;
      result.status       = frame_end ? end_status : StOk;
      result.number       = frame_end ? $signed(end_number) : 64'sd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         kind_ff    <= CmdSimple;
         saw_cr_ff  <= 1'b0;
         acc_ff     <= 64'd0;
         neg_ff     <= 1'b0;
         seen_ff    <= 1'b0;
         stopped_ff <= 1'b0;
         nerr_ff    <= 1'b0;
         remain_ff  <= '0;
      end else begin
         phase_ff   <= phase_in;
         kind_ff    <= kind_in;
         saw_cr_ff  <= saw_cr_in;
         acc_ff     <= acc_in;
         neg_ff     <= neg_in;
         seen_ff    <= seen_in;
         stopped_ff <= stopped_in;
         nerr_ff    <= nerr_in;
         remain_ff  <= remain_in;
      end
   end

endmodule

@@ bench/testbench.sv @@
module testbench;
   import rfp_pkg::*;

   localparam command_type CmdUnknown = 2'd3;

   typedef enum logic [2:0] {
      PhIdle, PhString, PhLead, PhDigits, PhPayload, PhWantCr, PhWantLf
   } parse_phase_type;

   typedef struct packed {
      rfp_step_type   step;
      logic           typed;
      rfp_result_type result;
   } dir_row_type;

   logic clock;
   logic reset;

   rfp_req_if req();
   rfp_rsp_if rsp();
   rfp_csr_if csr();

   resp_frame_parser_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req),
      .rsp_bus (rsp),
      .csr_bus (csr)
   );

   // shadow parse state
   command_type     frame_kind;
   parse_phase_type phase;
   logic            cr_seen;
   logic [63:0]     magnitude;
   logic            minus;
   logic            got_digit;
   logic            digits_done;
   logic            range_err;
   length_type      remain;
   length_type      bulk_limit;

   rfp_result_type pending_results[$];
   rfp_step_type   byte_stream[$];
   byte_type       frame_bytes[$];
   dir_row_type    dir_table[$];

   int   mismatch_count = 0;
   logic gaps_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic void clear_frame();
      frame_kind  = CmdSimple;
      phase       = PhIdle;
      cr_seen     = 1'b0;
      magnitude   = '0;
      minus       = 1'b0;
      got_digit   = 1'b0;
      digits_done = 1'b0;
      range_err   = 1'b0;
      remain      = '0;
   endfunction

   function automatic logic end_frame(input status_type st, input logic [63:0] num,
                                      output rfp_result_type r);
      r.is_frame_end = 1'b1;
      r.payload_byte = '0;
      r.status       = st;
      r.number       = num;
      clear_frame();
      return 1'b1;
   endfunction

   function automatic logic pass_byte(input byte_type b, output rfp_result_type r);
      r = '0;
      r.payload_byte = b;
      return 1'b1;
   endfunction

   // LF of an integer line or of a bulk length line
   function automatic logic close_number(output rfp_result_type r);
      logic        bad;
      logic [63:0] val;
      r = '0;
      bad = !got_digit || range_err || (!minus && magnitude > 64'h7FFF_FFFF_FFFF_FFFF);
      val = minus ? -magnitude : magnitude;
      if (frame_kind == CmdInteger)
         return bad ? end_frame(StNumber, '0, r) : end_frame(StOk, val, r);
      if (bad)
         return end_frame(StNumber, '0, r);
      if ((minus && magnitude != 0) || magnitude > {34'd0, bulk_limit})
         return end_frame(StFraming, val, r);
      magnitude = {34'd0, magnitude[29:0]};
      minus     = 1'b0;
      cr_seen   = 1'b0;
      remain    = magnitude[29:0];
      phase     = (remain != 0) ? PhPayload : PhWantCr;
      return 1'b0;
   endfunction

   function automatic logic parse_byte(input rfp_step_type s, output rfp_result_type r);
      byte_type b;
      b = s.data_byte;
      r = '0;
      if (phase == PhIdle) begin
         frame_kind = s.command;
         case (s.command)
            CmdSimple: phase = PhString;
            CmdInteger, CmdBulk: phase = PhLead;
            default: return end_frame(StFraming, '0, r);
         endcase
      end
      case (phase)
         PhPayload: begin
            remain = remain - 1'b1;
            if (remain == 0)
               phase = PhWantCr;
            return pass_byte(b, r);
         end
         PhWantCr: begin
            if (b == ByteCr) begin
               phase = PhWantLf;
               return 1'b0;
            end
            return end_frame(StFraming, magnitude, r);
         end
         PhWantLf: return end_frame((b == ByteLf) ? StOk : StFraming, magnitude, r);
         default: ;
      endcase
      if (cr_seen) begin
         if (b != ByteLf)
            return end_frame(StFraming, '0, r);
         if (phase == PhString)
            return end_frame(StOk, '0, r);
         return close_number(r);
      end
      if (b == ByteCr) begin
         cr_seen = 1'b1;
         return 1'b0;
      end
      if (b == ByteLf)
         return end_frame(StFraming, '0, r);
      if (phase == PhString)
         return pass_byte(b, r);
      if (phase == PhLead) begin
         if (b == ByteSpace || b == ByteTab || b == ByteVt || b == ByteFf)
            return 1'b0;
         phase = PhDigits;
         if (b == BytePlus)
            return 1'b0;
         if (b == ByteMinus) begin
            minus = 1'b1;
            return 1'b0;
         end
      end
      if (!digits_done) begin
         if (b >= ByteZero && b <= ByteNine) begin
            got_digit = 1'b1;
            if (!range_err) begin
               if (magnitude > MagTenth || (magnitude == MagTenth && (b - ByteZero) > 8))
                  range_err = 1'b1;
               else
                  magnitude = magnitude * 10 + (b - ByteZero);
            end
         end else begin
            digits_done = 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // ---------------- directed table ----------------

   function automatic void row(input command_type c, input byte_type b);
      dir_row_type d;
      d = '0;
      d.step.command   = c;
      d.step.data_byte = b;
      dir_table.push_back(d);
   endfunction

   function automatic void row_end(input command_type c, input byte_type b,
                                   input status_type st, input logic [63:0] num);
      dir_row_type d;
      d = '0;
      d.step.command       = c;
      d.step.data_byte     = b;
      d.typed              = 1'b1;
      d.result.is_frame_end = 1'b1;
      d.result.status      = st;
      d.result.number      = num;
      dir_table.push_back(d);
   endfunction

   function automatic void row_byte(input command_type c, input byte_type b);
      dir_row_type d;
      d = '0;
      d.step.command       = c;
      d.step.data_byte     = b;
      d.typed              = 1'b1;
      d.result.payload_byte = b;
      dir_table.push_back(d);
   endfunction

   // ---------------- random frames ----------------

   function automatic byte_type line_char();
      byte_type b;
      do b = byte_type'($urandom_range(0, 255)); while (b == ByteCr || b == ByteLf);
      return b;
   endfunction

   function automatic void put_decimal(input logic [63:0] v);
      byte_type digs[$];
      digs = {};
      do begin
         digs.push_front(byte_type'(v % 10) + ByteZero);
         v = v / 10;
      end while (v != 0);
      foreach (digs[i])
         frame_bytes.push_back(digs[i]);
   endfunction

   // more than 19 digits: always out of range
   function automatic void put_long_digits();
      frame_bytes.push_back(ByteZero + byte_type'($urandom_range(1, 9)));
      repeat ($urandom_range(19, 24))
         frame_bytes.push_back(ByteZero + byte_type'($urandom_range(0, 9)));
   endfunction

   function automatic void put_crlf();
      frame_bytes.push_back(ByteCr);
      frame_bytes.push_back(ByteLf);
   endfunction

   function automatic void put_line_end();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) begin
         put_crlf();
      end else if (r < 93) begin
         frame_bytes.push_back(ByteCr);
         frame_bytes.push_back(line_char());
      end else begin
         frame_bytes.push_back(ByteLf);
      end
   endfunction

   function automatic void put_trailer();
      int r;
      byte_type b;
      r = $urandom_range(0, 99);
      if (r < 88) begin
         put_crlf();
      end else if (r < 94) begin
         do b = line_char(); while (b == ByteCr);
         frame_bytes.push_back(b);
      end else begin
         frame_bytes.push_back(ByteCr);
         frame_bytes.push_back(line_char());
      end
   endfunction

   function automatic void put_blank();
      case ($urandom_range(0, 3))
         0: frame_bytes.push_back(ByteSpace);
         1: frame_bytes.push_back(ByteTab);
         2: frame_bytes.push_back(ByteVt);
         default: frame_bytes.push_back(ByteFf);
      endcase
   endfunction

   function automatic void put_integer_line();
      int       r;
      byte_type b;
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 2)) put_blank();
      r = $urandom_range(0, 99);
      if (r >= 80)
         frame_bytes.push_back(ByteMinus);
      else if (r >= 60)
         frame_bytes.push_back(BytePlus);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: put_decimal(64'($urandom_range(0, 1000)));
         4: put_decimal({$urandom, $urandom});
         5: put_decimal(64'd9223372036854775807 + 64'($urandom_range(0, 2)));
         6: put_decimal(64'd9223372036854775806);
         7: put_decimal(64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3)));
         8: ;
         default: put_long_digits();
      endcase
      if ($urandom_range(0, 4) == 0) begin
         do b = line_char(); while (b >= ByteZero && b <= ByteNine);
         frame_bytes.push_back(b);
         repeat ($urandom_range(0, 3)) frame_bytes.push_back(line_char());
      end
      put_line_end();
   endfunction

   function automatic void put_bulk_frame();
      int n;
      if ($urandom_range(0, 9) == 0)
         frame_bytes.push_back(ByteSpace);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5, 6: begin
            n = $urandom_range(0, (bulk_limit < 12) ? bulk_limit : 12);
            if ($urandom_range(0, 7) == 0)
               frame_bytes.push_back(BytePlus);
            put_decimal(64'(n));
            put_crlf();
            repeat (n) frame_bytes.push_back(byte_type'($urandom_range(0, 255)));
            put_trailer();
         end
         7: begin
            put_decimal(64'(bulk_limit) + 64'd1 + 64'($urandom_range(0, 3)));
            put_crlf();
         end
         8: begin
            // minus zero is a valid empty payload
            n = $urandom_range(0, 3);
            frame_bytes.push_back(ByteMinus);
            put_decimal(64'(n));
            put_crlf();
            if (n == 0)
               put_trailer();
         end
         default: begin
            if ($urandom_range(0, 1) == 0)
               put_decimal({$urandom, $urandom});
            else
               put_long_digits();
            put_crlf();
         end
      endcase
   endfunction

   function automatic void add_frame();
      int           pick;
      command_type  c;
      rfp_step_type s;
      frame_bytes = {};
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
         c = CmdSimple;
         repeat ($urandom_range(0, 8)) frame_bytes.push_back(line_char());
         put_line_end();
      end else if (pick < 56) begin
         c = CmdInteger;
         put_integer_line();
      end else if (pick < 86) begin
         c = CmdBulk;
         put_bulk_frame();
      end else if (pick < 93) begin
         c = CmdUnknown;
         frame_bytes.push_back(byte_type'($urandom_range(0, 255)));
      end else begin
         c = command_type'($urandom_range(0, 3));
         repeat ($urandom_range(1, 6))
            frame_bytes.push_back(byte_type'($urandom_range(0, 255)));
      end
      // command only matters on the first byte; scramble it elsewhere
      foreach (frame_bytes[i]) begin
         s.command   = (i == 0) ? c : command_type'($urandom_range(0, 3));
         s.data_byte = frame_bytes[i];
         byte_stream.push_back(s);
      end
   endfunction

   // ---------------- drivers ----------------

   task automatic send_step(input rfp_step_type s, input logic typed,
                            input rfp_result_type typed_result);
      rfp_result_type r;
      logic           has;
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.command   <= s.command;
      req.data_byte <= s.data_byte;
      do @(posedge clock); while (!req.ready);
      has = parse_byte(s, r);
      if (typed)
         pending_results.push_back(typed_result);
      else if (has)
         pending_results.push_back(r);
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_limit(input length_type v);
      csr.valid      <= 1'b1;
      csr.write_data <= v;
      do @(posedge clock); while (!csr.ready);
      csr.valid  <= 1'b0;
      bulk_limit = v;
   endtask

   initial begin
      rsp.ready = 1'b0;
      @(posedge clock);
      forever begin
         @(posedge clock);
         if (gaps_on && $urandom_range(0, 9) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      rfp_result_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = {rsp.is_frame_end, rsp.payload_byte, rsp.status, rsp.number};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: end=%0d byte=%02h status=%0d number=%0d",
                        got.is_frame_end, got.payload_byte, got.status, got.number);
         end else begin
            want = pending_results.pop_front();
            if (got.is_frame_end !== want.is_frame_end ||
                got.payload_byte !== want.payload_byte ||
                got.status !== want.status || got.number !== want.number) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: expected end=%0d byte=%02h status=%0d number=%0d,",
                            " got end=%0d byte=%02h status=%0d number=%0d"},
                           want.is_frame_end, want.payload_byte, want.status, want.number,
                           got.is_frame_end, got.payload_byte, got.status, got.number);
            end
         end
      end
   end

   initial begin
      rfp_step_type s;
      int           count;
      int           guard;
      length_type   limit;
      req.valid      = 1'b0;
      req.command    = CmdSimple;
      req.data_byte  = '0;
      csr.valid      = 1'b0;
      csr.write_data = MaxBulkReset;
      reset          = 1'b1;
      clear_frame();
      bulk_limit = MaxBulkReset;

      row_end(CmdUnknown, 8'hFF, StFraming, 0);
      row_byte(CmdSimple, 8'h00);
      row_byte(CmdUnknown, 8'hFF);
      row(CmdSimple, ByteCr);
      row_end(CmdSimple, ByteLf, StOk, 0);
      row_end(CmdSimple, ByteLf, StFraming, 0);        // lone LF
      row(CmdSimple, ByteCr);
      row_end(CmdSimple, "x", StFraming, 0);           // lone CR
      row(CmdInteger, ByteTab);
      row(CmdInteger, ByteMinus);
      row(CmdSimple, "4");
      row(CmdSimple, "2");
      row(CmdSimple, "z");                             // trailing junk
      row(CmdSimple, ByteCr);
      row_end(CmdSimple, ByteLf, StOk, -64'sd42);
      row(CmdInteger, ByteCr);
      row_end(CmdInteger, ByteLf, StNumber, 0);        // no digits
      row(CmdBulk, "1");
      row(CmdSimple, ByteCr);
      row(CmdSimple, ByteLf);
      row_byte(CmdSimple, "Q");
      row(CmdSimple, ByteCr);
      row_end(CmdSimple, ByteLf, StOk, 1);
      row(CmdBulk, "0");
      row(CmdSimple, ByteCr);
      row(CmdSimple, ByteLf);
      row_end(CmdSimple, "X", StFraming, 0);           // missing trailer

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i])
         send_step(dir_table[i].step, dir_table[i].typed, dir_table[i].result);

      for (int p = 0; p < 5; p++) begin
         drain_results();
         repeat (8) @(posedge clock);
         case (p)
            0: limit = '0;
            1: limit = MaxBulkReset;
            2: limit = length_type'($urandom_range(1, 12));
            3: limit = length_type'($urandom_range(0, MaxBulkReset));
            default: limit = length_type'($urandom_range(3, 8));
         endcase
         write_limit(limit);
         gaps_on = (p != 4);
         count = 0;
         while (count < 260) begin
            if (byte_stream.size() == 0)
               add_frame();
            s = byte_stream.pop_front();
            if (gaps_on && $urandom_range(0, 199) == 0)
               drain_results();
            send_step(s, 1'b0, '0);
            count++;
         end
      end

      req.valid <= 1'b0;
      guard = 0;
      while (pending_results.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      if (pending_results.size() != 0)
         mismatch_count++;
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
